/* rtl/rvcd_pkg.sv */
`timescale 1ns / 1ps
// Shared constants and types for the compressed instruction decoder.
// No dependencies; imported by rvcd_expand and rvc_instruction_decoder_top.
package rvcd_pkg;

	localparam int ADDR_WIDTH = 32;

	// Register indexes on the configuration channel
	localparam logic [1:0] CFG_BASE_WIDTH   = 2'd0;
	localparam logic [1:0] CFG_FLOAT_SINGLE = 2'd1;
	localparam logic [1:0] CFG_FLOAT_DOUBLE = 2'd2;

	// Base width modes
	localparam logic [1:0] BW_RV32 = 2'd0;

	// Expanded operation codes
	localparam logic [4:0] OP_ADDI    = 5'd0;
	localparam logic [4:0] OP_ADDIW   = 5'd1;
	localparam logic [4:0] OP_LUI     = 5'd2;
	localparam logic [4:0] OP_SLLI    = 5'd3;
	localparam logic [4:0] OP_SRLI    = 5'd4;
	localparam logic [4:0] OP_SRAI    = 5'd5;
	localparam logic [4:0] OP_ANDI    = 5'd6;
	localparam logic [4:0] OP_SUB     = 5'd7;
	localparam logic [4:0] OP_XOR     = 5'd8;
	localparam logic [4:0] OP_OR      = 5'd9;
	localparam logic [4:0] OP_AND     = 5'd10;
	localparam logic [4:0] OP_SUBW    = 5'd11;
	localparam logic [4:0] OP_ADDW    = 5'd12;
	localparam logic [4:0] OP_ADD     = 5'd13;
	localparam logic [4:0] OP_JAL     = 5'd14;
	localparam logic [4:0] OP_JALR    = 5'd15;
	localparam logic [4:0] OP_BEQ     = 5'd16;
	localparam logic [4:0] OP_BNE     = 5'd17;
	localparam logic [4:0] OP_LW      = 5'd18;
	localparam logic [4:0] OP_LD      = 5'd19;
	localparam logic [4:0] OP_LQ      = 5'd20;
	localparam logic [4:0] OP_FLW     = 5'd21;
	localparam logic [4:0] OP_FLD     = 5'd22;
	localparam logic [4:0] OP_SW      = 5'd23;
	localparam logic [4:0] OP_SD      = 5'd24;
	localparam logic [4:0] OP_SQ      = 5'd25;
	localparam logic [4:0] OP_FSW     = 5'd26;
	localparam logic [4:0] OP_FSD     = 5'd27;
	localparam logic [4:0] OP_EBREAK  = 5'd28;
	localparam logic [4:0] OP_ILLEGAL = 5'd30;

	// Register numbers implied by some forms
	localparam logic [4:0] REG_ZERO = 5'd0;
	localparam logic [4:0] REG_RA   = 5'd1;
	localparam logic [4:0] REG_SP   = 5'd2;

	typedef struct packed {
		logic [1:0] base_width_mode;
		logic       float_single_enable;
		logic       float_double_enable;
	} cfg_t;

	typedef struct packed {
		logic [4:0]            op;
		logic [4:0]            rd;
		logic [4:0]            rs1;
		logic [4:0]            rs2;
		logic signed [11:0]    imm;
		logic [ADDR_WIDTH-1:0] target;
		logic                  data_reg_is_fp;
		logic                  illegal;
	} result_t;

endpackage

/* rtl/rvcd_expand.sv */
`timescale 1ns / 1ps
// Combinational expansion of one compressed halfword into a full result word.
// Depends on rvcd_pkg for operation codes, configuration and result types.
module rvcd_expand (
	input  rvcd_pkg::cfg_t                        cfg,
	input  logic [15:0]                           instr,
	input  logic [rvcd_pkg::ADDR_WIDTH-1:0]       pc,
	output rvcd_pkg::result_t                     res
);
	import rvcd_pkg::*;

	logic              is32, is128;
	logic [2:0]        f3;
	logic              b12;
	logic [4:0]        r, r2, rp, r2p;
	logic [5:0]        u6;
	logic signed [11:0] s6;
	logic [9:0]        t_a4spn, t_a16sp, olq, osq;
	logic [6:0]        ow;
	logic [7:0]        od, olw, osw;
	logic [8:0]        oq, ob, old, osd;
	logic [11:0]       oj;
	logic [6:0]        shamt;
	logic              shift_ill;

	logic [4:0]         op, rd, rs1, rs2;
	logic signed [11:0] imm;
	logic               has_target, fp, ill;

	assign is32  = (cfg.base_width_mode == BW_RV32);
	assign is128 = cfg.base_width_mode[1];
	assign f3    = instr[15:13];
	assign b12   = instr[12];
	assign r     = instr[11:7];
	assign r2    = instr[6:2];
	assign rp    = {2'b01, instr[9:7]};
	assign r2p   = {2'b01, instr[4:2]};
	assign u6    = {b12, r2};
	assign s6    = 12'($signed(u6));

	assign t_a4spn = {instr[10:7], instr[12:11], instr[5], instr[6], 2'b00};
	assign ow      = {instr[5], instr[12:10], instr[6], 2'b00};
	assign od      = {instr[6:5], instr[12:10], 3'b000};
	assign oq      = {instr[10], instr[6:5], instr[12:11], 4'b0000};
	assign oj      = {instr[12], instr[8], instr[10:9], instr[6], instr[7], instr[2],
			instr[11], instr[5:3], 1'b0};
	assign ob      = {instr[12], instr[6:5], instr[2], instr[11:10], instr[4:3], 1'b0};
	assign t_a16sp = {instr[12], instr[4:3], instr[5], instr[2], instr[6], 4'b0000};
	assign olw     = {instr[3:2], instr[12], instr[6:4], 2'b00};
	assign old     = {instr[4:2], instr[12], instr[6:5], 3'b000};
	assign olq     = {instr[5:2], instr[12], instr[6], 4'b0000};
	assign osw     = {instr[8:7], instr[12:9], 2'b00};
	assign osd     = {instr[9:7], instr[12:10], 3'b000};
	assign osq     = {instr[10:7], instr[12:11], 4'b0000};

	// Shift amount: zero means 64 on RV128, reserved otherwise; RV32 has no bit 5
	always_comb begin
		shamt     = {1'b0, u6};
		shift_ill = 1'b0;
		if (is32 && b12) begin
			shift_ill = 1'b1;
		end else if (u6 == 6'd0) begin
			if (is128) shamt = 7'd64;
			else shift_ill = 1'b1;
		end
	end

	always_comb begin
		op         = OP_ILLEGAL;
		rd         = REG_ZERO;
		rs1        = REG_ZERO;
		rs2        = REG_ZERO;
		imm        = '0;
		has_target = 1'b0;
		fp         = 1'b0;
		ill        = 1'b0;
		case (instr[1:0])
			2'b00: begin
				case (f3)
					3'd0: begin
						if (t_a4spn == '0) ill = 1'b1;
						else begin
							op = OP_ADDI; rd = r2p; rs1 = REG_SP; imm = 12'(t_a4spn);
						end
					end
					3'd1: begin
						rd = r2p; rs1 = rp;
						if (is128) begin
							op = OP_LQ; imm = 12'(oq);
						end else if (cfg.float_double_enable) begin
							op = OP_FLD; imm = 12'(od); fp = 1'b1;
						end else ill = 1'b1;
					end
					3'd2: begin
						op = OP_LW; rd = r2p; rs1 = rp; imm = 12'(ow);
					end
					3'd3: begin
						rd = r2p; rs1 = rp;
						if (!is32) begin
							op = OP_LD; imm = 12'(od);
						end else if (cfg.float_single_enable) begin
							op = OP_FLW; imm = 12'(ow); fp = 1'b1;
						end else ill = 1'b1;
					end
					3'd5: begin
						rs1 = rp; rs2 = r2p;
						if (is128) begin
							op = OP_SQ; imm = 12'(oq);
						end else if (cfg.float_double_enable) begin
							op = OP_FSD; imm = 12'(od); fp = 1'b1;
						end else ill = 1'b1;
					end
					3'd6: begin
						op = OP_SW; rs1 = rp; rs2 = r2p; imm = 12'(ow);
					end
					3'd7: begin
						rs1 = rp; rs2 = r2p;
						if (!is32) begin
							op = OP_SD; imm = 12'(od);
						end else if (cfg.float_single_enable) begin
							op = OP_FSW; imm = 12'(ow); fp = 1'b1;
						end else ill = 1'b1;
					end
					default: ill = 1'b1;
				endcase
			end
			2'b01: begin
				case (f3)
					3'd0: begin
						op = OP_ADDI; rd = r; rs1 = r; imm = s6;
					end
					3'd1: begin
						if (is32) begin
							op = OP_JAL; rd = REG_RA; imm = $signed(oj); has_target = 1'b1;
						end else if (r == REG_ZERO) ill = 1'b1;
						else begin
							op = OP_ADDIW; rd = r; rs1 = r; imm = s6;
						end
					end
					3'd2: begin
						op = OP_ADDI; rd = r; imm = s6;
					end
					3'd3: begin
						if (r == REG_SP) begin
							if (t_a16sp == '0) ill = 1'b1;
							else begin
								op = OP_ADDI; rd = REG_SP; rs1 = REG_SP;
								imm = 12'($signed(t_a16sp));
							end
						end else if (u6 == '0) ill = 1'b1;
						else begin
							op = OP_LUI; rd = r; imm = s6;
						end
					end
					3'd4: begin
						case (instr[11:10])
							2'd0, 2'd1: begin
								if (shift_ill) ill = 1'b1;
								else begin
									op  = instr[10] ? OP_SRAI : OP_SRLI;
									rd  = rp; rs1 = rp; imm = 12'(shamt);
								end
							end
							2'd2: begin
								op = OP_ANDI; rd = rp; rs1 = rp; imm = s6;
							end
							default: begin
								rd = rp; rs1 = rp; rs2 = r2p;
								if (!b12) begin
									case (instr[6:5])
										2'd0:    op = OP_SUB;
										2'd1:    op = OP_XOR;
										2'd2:    op = OP_OR;
										default: op = OP_AND;
									endcase
								end else if (!instr[6] && !is32) begin
									op = instr[5] ? OP_ADDW : OP_SUBW;
								end else ill = 1'b1;
							end
						endcase
					end
					3'd5: begin
						op = OP_JAL; imm = $signed(oj); has_target = 1'b1;
					end
					default: begin
						op  = (f3 == 3'd6) ? OP_BEQ : OP_BNE;
						rs1 = rp; imm = 12'($signed(ob)); has_target = 1'b1;
					end
				endcase
			end
			2'b10: begin
				case (f3)
					3'd0: begin
						if (shift_ill) ill = 1'b1;
						else begin
							op = OP_SLLI; rd = r; rs1 = r; imm = 12'(shamt);
						end
					end
					3'd1: begin
						rd = r; rs1 = REG_SP;
						if (is128) begin
							if (r == REG_ZERO) ill = 1'b1;
							else begin
								op = OP_LQ; imm = 12'(olq);
							end
						end else if (cfg.float_double_enable) begin
							op = OP_FLD; imm = 12'(old); fp = 1'b1;
						end else ill = 1'b1;
					end
					3'd2: begin
						if (r == REG_ZERO) ill = 1'b1;
						else begin
							op = OP_LW; rd = r; rs1 = REG_SP; imm = 12'(olw);
						end
					end
					3'd3: begin
						rd = r; rs1 = REG_SP;
						if (!is32) begin
							if (r == REG_ZERO) ill = 1'b1;
							else begin
								op = OP_LD; imm = 12'(old);
							end
						end else if (cfg.float_single_enable) begin
							op = OP_FLW; imm = 12'(olw); fp = 1'b1;
						end else ill = 1'b1;
					end
					3'd4: begin
						if (r2 != REG_ZERO) begin
							op = OP_ADD; rd = r; rs2 = r2;
							rs1 = b12 ? r : REG_ZERO;
						end else if (r != REG_ZERO) begin
							op = OP_JALR; rs1 = r;
							rd = b12 ? REG_RA : REG_ZERO;
						end else if (b12) begin
							op = OP_EBREAK;
						end else ill = 1'b1;
					end
					3'd5: begin
						rs1 = REG_SP; rs2 = r2;
						if (is128) begin
							op = OP_SQ; imm = 12'(osq);
						end else if (cfg.float_double_enable) begin
							op = OP_FSD; imm = 12'(osd); fp = 1'b1;
						end else ill = 1'b1;
					end
					3'd6: begin
						op = OP_SW; rs1 = REG_SP; rs2 = r2; imm = 12'(osw);
					end
					default: begin
						rs1 = REG_SP; rs2 = r2;
						if (!is32) begin
							op = OP_SD; imm = 12'(osd);
						end else if (cfg.float_single_enable) begin
							op = OP_FSW; imm = 12'(osw); fp = 1'b1;
						end else ill = 1'b1;
					end
				endcase
			end
			default: ill = 1'b1;
		endcase
	end

	// Illegal words carry only the flag and the illegal code; targets wrap
	always_comb begin
		res = '0;
		if (ill) begin
			res.op      = OP_ILLEGAL;
			res.illegal = 1'b1;
		end else begin
			res.op             = op;
			res.rd             = rd;
			res.rs1            = rs1;
			res.rs2            = rs2;
			res.imm            = imm;
			res.data_reg_is_fp = fp;
			if (has_target)
				res.target = pc + ADDR_WIDTH'(imm);
		end
	end

endmodule

/* rtl/rvc_instruction_decoder_top.sv */
`timescale 1ns / 1ps
// Top level of the compressed instruction decoder: stream ports, configuration
// registers, input and result registers. Depends on rvcd_pkg and rvcd_expand.

// The decoder takes one 16-bit compressed instruction and its 32-bit address per
// input word and returns one expanded result word for each: operation code,
// full register numbers, immediate, branch or jump target (address plus offset,
// wrapping) and the illegal flag. It accepts a word every cycle while the
// output side is not stalled. Each word passes two registers (input register,
// then result register, with the decode and the one 32-bit target adder
// between them) and its result is held in the result register until taken.
// Both stages hold under back-pressure and s_axis_tready follows the output
// side, so no word is lost or repeated. Configuration (base width RV32, RV64
// or RV128, and the F and D enables) is written through the cfg channel,
// which is always ready; write it only while no word is in flight. Index 3
// on that channel is ignored. An illegal result carries op 30, the illegal
// flag and zeros in every other field.
module rvc_instruction_decoder_top (
	input  logic        clk,
	input  logic        arst_n,
	// Input words
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [47:0] s_axis_tdata,  // instr[15:0], pc[47:16]
	// Result words
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [63:0] m_axis_tdata,  // op[4:0], rd[9:5], rs1[14:10], rs2[19:15],
	                                   // imm[31:20], target[63:32]
	output logic [1:0]  m_axis_tuser,  // data_reg_is_fp[0], illegal[1]
	// Configuration writes
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [1:0]  cfg_data
);
	import rvcd_pkg::*;

	cfg_t                  cfg_q;
	logic                  valid_s1, valid_s2;
	logic [15:0]           instr_s1;
	logic [ADDR_WIDTH-1:0] pc_s1;
	result_t               dec_res;
	result_t               res_s2;
	logic                  ready_s1, ready_s2;

	// Configuration registers: always ready, take the write on the handshake
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_BASE_WIDTH:   cfg_q.base_width_mode     <= cfg_data;
				CFG_FLOAT_SINGLE: cfg_q.float_single_enable <= cfg_data[0];
				CFG_FLOAT_DOUBLE: cfg_q.float_double_enable <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// Each stage advances when it is empty or the stage after it moves on
	assign ready_s2      = !valid_s2 || m_axis_tready;
	assign ready_s1      = !valid_s1 || ready_s2;
	assign s_axis_tready = ready_s1;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (ready_s1) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s1 && s_axis_tvalid) begin
			instr_s1 <= s_axis_tdata[15:0];
			pc_s1    <= s_axis_tdata[47:16];
		end
	end

	rvcd_expand u_expand (
		.cfg   (cfg_q),
		.instr (instr_s1),
		.pc    (pc_s1),
		.res   (dec_res)
	);

	// Result register: hold while the output side stalls
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (ready_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s2 && valid_s1) begin
			res_s2 <= dec_res;
		end
	end

	assign m_axis_tvalid = valid_s2;
	assign m_axis_tdata  = {res_s2.target, res_s2.imm, res_s2.rs2, res_s2.rs1,
			res_s2.rd, res_s2.op};
	assign m_axis_tuser  = {res_s2.illegal, res_s2.data_reg_is_fp};

endmodule
